// ===== rtl/core/skcr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package skcr_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_SMOOTHING_GAIN = 2'd0;
	localparam logic [1:0] REG_CHANGE_DEADBAND = 2'd1;
	localparam logic [1:0] REG_MIN_SEND_INTERVAL = 2'd2;

	// Reset values of the registers
	localparam logic [7:0] GAIN_RESET = 8'd64;
	localparam logic [7:0] DEADBAND_RESET = 8'd2;
	localparam logic [7:0] INTERVAL_RESET = 8'd20;

	// Item codes
	localparam logic CMD_FILTER = 1'b0;
	localparam logic CMD_RELOAD = 1'b1;

	localparam logic [6:0] BIG_CHANGE = 7'd8;
	localparam logic [6:0] LEVEL_MAX = 7'd127;
	localparam logic [9:0] SAMPLE_MAX = 10'd1023;

	// Beat passed from the filter stage to the decision stage
	typedef struct packed {
		logic        cmd;
		logic [9:0]  level;
		logic [31:0] time_ms;
	} item_t;

	// floor(v * 127 / 1023), clamped at 127. The division by 1023 uses
	// (m + m/1024) / 1024 as an estimate that is low by at most one,
	// then one compare and increment.
	function automatic logic [6:0] map_level(input logic [9:0] v);
		logic [16:0] m;
		logic [17:0] sum;
		logic [7:0]  q_est;
		logic [17:0] rem;
		logic [7:0]  q;
		m = ({7'd0, v} << 7) - {7'd0, v};
		sum = {1'b0, m} + {11'd0, m[16:10]};
		q_est = sum[17:10];
		rem = {1'b0, m} - ({10'd0, q_est} << 10) + {10'd0, q_est};
		q = (rem >= {8'd0, SAMPLE_MAX}) ? q_est + 8'd1 : q_est;
		map_level = (q > {1'b0, LEVEL_MAX}) ? LEVEL_MAX : q[6:0];
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/skcr_ema.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skcr_ema (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire logic             cmd,
	input  wire logic [9:0]       sample,
	input  wire logic [31:0]      time_ms,
	input  wire logic [7:0]       gain,
	output skcr_pkg::item_t       item_s1
);

	logic        [9:0]  filtered_q;
	logic signed [10:0] err;
	logic signed [19:0] prod;
	logic signed [19:0] step;
	logic signed [11:0] nf;
	logic        [9:0]  nf_clamped;
	logic        [9:0]  next_level;

	// Move the filtered level by floor(err * gain / 256)
	assign err = $signed({1'b0, sample}) - $signed({1'b0, filtered_q});
	assign prod = err * $signed({1'b0, gain});
	assign step = prod >>> 8;
	assign nf = $signed({2'b00, filtered_q}) + step[11:0];

	// Clamp to the sample range
	always_comb begin
		if (nf[11]) begin
			nf_clamped = 10'd0;
		end else if (nf[10]) begin
			nf_clamped = skcr_pkg::SAMPLE_MAX;
		end else begin
			nf_clamped = nf[9:0];
		end
	end

	assign next_level = (cmd == skcr_pkg::CMD_RELOAD) ? sample : nf_clamped;

	// Update filter state on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filtered_q <= 10'd0;
		end else if (load) begin
			filtered_q <= next_level;
		end
	end

	// Stage register toward the decision logic
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1.cmd <= cmd;
			item_s1.level <= next_level;
			item_s1.time_ms <= time_ms;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/smoothed_knob_change_reporter.sv =====
// A result beat passes through the filter stage register and then the output register.
// Throughput: one beat per cycle while the output is not stalled; the filter
// stage and the send decision stage each close their state loop in their own registers.
// Output backpressure stalls both stages; the input is still taken while a
// result waits if the filter stage is empty.
// Reset (arst_n low) clears valid, filter and send state; register defaults 64, 2, 20.
`timescale 1ns / 1ps
`default_nettype none

module smoothed_knob_change_reporter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [47:0] s_tdata,   // [9:0] sample, [41:10] time_ms, zero above
	input  wire logic        s_tuser,   // [0] cmd
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [7:0]  m_tdata,   // [6:0] level_value, zero above
	output      logic [1:0]  m_tuser    // [0] send_now, [1] significant
);

	logic [7:0] gain_q;
	logic [7:0] deadband_q;
	logic [7:0] interval_q;

	logic v_s1;
	logic v_s2;
	logic adv2;
	logic accept;
	skcr_pkg::item_t item_s1;

	logic [6:0]  last_sent_q;
	logic [31:0] last_time_q;
	logic        force_q;

	logic [6:0]  level;
	logic [6:0]  delta;
	logic        sig;
	logic        big;
	logic [31:0] elapsed;
	logic        send;
	logic        force_next;

	logic       send_s2;
	logic [6:0] level_s2;
	logic       sig_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= skcr_pkg::GAIN_RESET;
			deadband_q <= skcr_pkg::DEADBAND_RESET;
			interval_q <= skcr_pkg::INTERVAL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				skcr_pkg::REG_SMOOTHING_GAIN: gain_q <= cfg_wdata;
				skcr_pkg::REG_CHANGE_DEADBAND: deadband_q <= cfg_wdata;
				skcr_pkg::REG_MIN_SEND_INTERVAL: interval_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow: stage two is the output register
	assign adv2 = !v_s2 || m_tready;
	assign s_tready = !v_s1 || adv2;
	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				v_s1 <= s_tvalid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
		end
	end

	skcr_ema u_ema (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.cmd     (s_tuser),
		.sample  (s_tdata[9:0]),
		.time_ms (s_tdata[41:10]),
		.gain    (gain_q),
		.item_s1 (item_s1)
	);

	// Map and compare with the last sent value
	assign level = skcr_pkg::map_level(item_s1.level);
	assign delta = (level >= last_sent_q) ? level - last_sent_q : last_sent_q - level;
	assign sig = {1'b0, delta} >= deadband_q;
	assign big = delta >= skcr_pkg::BIG_CHANGE;
	assign elapsed = item_s1.time_ms - last_time_q;

	// Send decision in priority order
	always_comb begin
		send = 1'b0;
		force_next = force_q;
		priority if (force_q) begin
			send = 1'b1;
			force_next = 1'b0;
		end else if (sig && (elapsed >= {24'd0, interval_q})) begin
			send = 1'b1;
		end else if (big) begin
			send = 1'b1;
			force_next = 1'b1;
		end else begin
			send = 1'b0;
		end
	end

	// Advance the send state when a beat enters the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_sent_q <= 7'd0;
			last_time_q <= 32'd0;
			force_q <= 1'b0;
		end else if (adv2 && v_s1) begin
			if (item_s1.cmd == skcr_pkg::CMD_RELOAD) begin
				last_sent_q <= level;
				last_time_q <= 32'd0;
				force_q <= 1'b0;
			end else begin
				force_q <= force_next;
				if (send) begin
					last_sent_q <= level;
					last_time_q <= item_s1.time_ms;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			level_s2 <= level;
			if (item_s1.cmd == skcr_pkg::CMD_RELOAD) begin
				send_s2 <= 1'b0;
				sig_s2 <= 1'b0;
			end else begin
				send_s2 <= send;
				sig_s2 <= sig;
			end
		end
	end

	assign m_tvalid = v_s2;
	assign m_tdata = {1'b0, level_s2};
	assign m_tuser = {sig_s2, send_s2};

`ifndef SYNTH
	// A result that was sent matches the last sent value
	a_sent_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && send_s2) |-> (last_sent_q == level_s2))
		else $error("sent level differs from last sent state");

	// A pending force makes the next filter beat send
	a_force_sends: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && v_s1 && force_q && item_s1.cmd == skcr_pkg::CMD_FILTER) |=> send_s2)
		else $error("pending force did not send");

	// A reload clears the pending force and never sends
	a_reload_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && v_s1 && item_s1.cmd == skcr_pkg::CMD_RELOAD) |=> (!force_q && !send_s2))
		else $error("reload left force or send set");

	// With zero deadband every filter beat is significant
	a_zero_deadband: assert property (@(posedge clk) disable iff (!arst_n)
		(adv2 && v_s1 && deadband_q == 8'd0 && item_s1.cmd == skcr_pkg::CMD_FILTER)
		|=> sig_s2)
		else $error("zero deadband beat not significant");
`endif

endmodule

`default_nettype wire

// ===== verif/skcr_checker.sv =====
`timescale 1ns / 1ps

module skcr_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,   // [9:0] sample, [41:10] time_ms, zero above
	input  wire logic        s_tuser,   // [0] cmd
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [7:0]  m_tdata,   // [6:0] level_value, zero above
	input  wire logic [1:0]  m_tuser,   // [0] send_now, [1] significant
	output int               mismatches,
	output int               outstanding
);

	typedef struct packed {
		logic       send_now;
		logic [6:0] level_value;
		logic       significant;
	} knob_report_t;

	knob_report_t expected_reports[$];

	// Shadow registers and filter state
	logic [7:0]  gain;
	logic [7:0]  deadband;
	logic [7:0]  interval_ms;
	logic [9:0]  filt_level;
	logic [6:0]  last_sent;
	logic [31:0] last_time;
	logic        force_pending;

	knob_report_t want;
	knob_report_t fresh;
	logic         bad;

	// floor(v * 127 / 1023), clamped to the 7-bit range
	function automatic logic [6:0] scale_to_level(input logic [9:0] v);
		int q;
		q = int'(v) * int'(skcr_pkg::LEVEL_MAX) / int'(skcr_pkg::SAMPLE_MAX);
		if (q > int'(skcr_pkg::LEVEL_MAX))
			q = int'(skcr_pkg::LEVEL_MAX);
		return q[6:0];
	endfunction

	// Advance the filter and send decision by one beat
	task automatic predict_knob_report(input logic cmd, input logic [9:0] smp,
			input logic [31:0] now, output knob_report_t r);
		int          err;
		int          next_level;
		logic [6:0]  lvl;
		logic [6:0]  gap;
		logic [31:0] elapsed;
		logic        sig;
		logic        send;
		if (cmd == skcr_pkg::CMD_RELOAD) begin
			filt_level = smp;
			last_sent = scale_to_level(smp);
			last_time = '0;
			force_pending = 1'b0;
			r.send_now = 1'b0;
			r.level_value = last_sent;
			r.significant = 1'b0;
		end else begin
			err = int'(smp) - int'(filt_level);
			// arithmetic shift floors toward minus infinity
			next_level = int'(filt_level) + ((err * int'(gain)) >>> 8);
			if (next_level < 0)
				next_level = 0;
			if (next_level > int'(skcr_pkg::SAMPLE_MAX))
				next_level = int'(skcr_pkg::SAMPLE_MAX);
			filt_level = next_level[9:0];
			lvl = scale_to_level(filt_level);
			gap = (lvl >= last_sent) ? lvl - last_sent : last_sent - lvl;
			sig = ({1'b0, gap} >= deadband);
			elapsed = now - last_time;
			send = 1'b0;
			if (force_pending) begin
				send = 1'b1;
				force_pending = 1'b0;
			end else if (sig && elapsed >= {24'd0, interval_ms}) begin
				send = 1'b1;
			end else if (gap >= skcr_pkg::BIG_CHANGE) begin
				send = 1'b1;
				force_pending = 1'b1;
			end
			if (send) begin
				last_sent = lvl;
				last_time = now;
			end
			r.send_now = send;
			r.level_value = lvl;
			r.significant = sig;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain = skcr_pkg::GAIN_RESET;
			deadband = skcr_pkg::DEADBAND_RESET;
			interval_ms = skcr_pkg::INTERVAL_RESET;
			filt_level = '0;
			last_sent = '0;
			last_time = '0;
			force_pending = 1'b0;
			expected_reports.delete();
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			// Compare a result beat with the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_reports.size() == 0) begin
					$display("%0t: result beat with nothing expected: level %0d send %0b sig %0b",
						$time, m_tdata[6:0], m_tuser[0], m_tuser[1]);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_reports.pop_front();
					bad = 1'b0;
					if (m_tdata[6:0] !== want.level_value) begin
						$display("%0t: level_value expected %0d actual %0d",
							$time, want.level_value, m_tdata[6:0]);
						bad = 1'b1;
					end
					if (m_tuser[0] !== want.send_now) begin
						$display("%0t: send_now expected %0b actual %0b",
							$time, want.send_now, m_tuser[0]);
						bad = 1'b1;
					end
					if (m_tuser[1] !== want.significant) begin
						$display("%0t: significant expected %0b actual %0b",
							$time, want.significant, m_tuser[1]);
						bad = 1'b1;
					end
					if (bad)
						mismatches <= mismatches + 1;
				end
			end
			// Predict each accepted input beat
			if (s_tvalid && s_tready) begin
				predict_knob_report(s_tuser, s_tdata[9:0], s_tdata[41:10], fresh);
				expected_reports.push_back(fresh);
			end
			// Track register writes
			if (cfg_we) begin
				case (cfg_addr)
					skcr_pkg::REG_SMOOTHING_GAIN: gain = cfg_wdata;
					skcr_pkg::REG_CHANGE_DEADBAND: deadband = cfg_wdata;
					skcr_pkg::REG_MIN_SEND_INTERVAL: interval_ms = cfg_wdata;
					default: ;
				endcase
			end
			outstanding <= expected_reports.size();
		end
	end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS = 210;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [7:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // [9:0] sample, [41:10] time_ms, zero above
	logic        s_tuser;   // [0] cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [6:0] level_value, zero above
	logic [1:0]  m_tuser;   // [0] send_now, [1] significant

	int mismatches;
	int outstanding;

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_cycles;
	int stall_cycles;

	// Random walk state for well-formed sample streams
	int          walk_sample;
	logic [31:0] now_ms;

	smoothed_knob_change_reporter uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	skcr_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Offer one beat, idling first at the current sender rate
	task automatic offer_knob_beat(input logic cmd, input logic [9:0] smp,
			input logic [31:0] t);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {6'd0, t, smp};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Drop valid and hold until every predicted result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Write all three registers back to back while the block is idle
	task automatic load_settings(input logic [7:0] g, input logic [7:0] db,
			input logic [7:0] iv);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_addr <= skcr_pkg::REG_SMOOTHING_GAIN;
		cfg_wdata <= g;
		@(posedge clk);
		cfg_addr <= skcr_pkg::REG_CHANGE_DEADBAND;
		cfg_wdata <= db;
		@(posedge clk);
		cfg_addr <= skcr_pkg::REG_MIN_SEND_INTERVAL;
		cfg_wdata <= iv;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly a slowly moving knob with advancing time; some jumps and reloads
	task automatic random_knob_beat();
		int          pick;
		logic        cmd;
		logic [9:0]  smp;
		pick = $urandom_range(99);
		cmd = (pick < 4) ? skcr_pkg::CMD_RELOAD : skcr_pkg::CMD_FILTER;
		pick = $urandom_range(99);
		if (pick < 60) begin
			walk_sample = walk_sample + $urandom_range(80) - 40;
			if (walk_sample < 0)
				walk_sample = 0;
			if (walk_sample > 1023)
				walk_sample = 1023;
		end else if (pick < 80) begin
			walk_sample = $urandom_range(1023);
		end else if (pick < 90) begin
			walk_sample = 0;
		end else begin
			walk_sample = 1023;
		end
		smp = walk_sample[9:0];
		pick = $urandom_range(99);
		if (pick < 85)
			now_ms = now_ms + $urandom_range(30);
		else if (pick < 95)
			now_ms = now_ms + $urandom_range(400);
		else
			now_ms = $urandom;
		offer_knob_beat(cmd, smp, now_ms);
	endtask

	// Result side: random stalls, plus a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold_cycles) @(posedge clk);
				rx_hold_cycles = 0;
			end
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// End the run when nothing moves for too long
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cycles = 0;
			else
				stall_cycles = stall_cycles + 1;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		logic [7:0] g;
		logic [7:0] db;
		logic [7:0] iv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = skcr_pkg::CMD_FILTER;
		tx_idle_pct = 12;
		rx_idle_pct = 67;
		rx_hold_cycles = 0;
		walk_sample = 512;
		now_ms = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, big jumps, forced send, time wrap, reloads
		offer_knob_beat(skcr_pkg::CMD_RELOAD, 10'd0, 32'd0);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd5);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd6);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd7);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'hFFFF_FFF0);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'h0000_0010);
		offer_knob_beat(skcr_pkg::CMD_RELOAD, 10'd1023, 32'hFFFF_FFFF);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1000, 32'h5555_5555);
		offer_knob_beat(skcr_pkg::CMD_RELOAD, 10'd512, 32'hAAAA_AAAA);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd511, 32'd1);

		// Full gain, zero deadband, no rate limit
		load_settings(8'd255, 8'd0, 8'd0);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'd40);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd40);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd40);

		// Zero gain holds the filter; widest deadband and interval
		load_settings(8'd0, 8'd255, 8'd255);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd100);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'd500);
		offer_knob_beat(skcr_pkg::CMD_RELOAD, 10'd700, 32'd600);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'd900);

		// Smallest gain: the filter moves by floor(err / 256), up by one and then down by three
		load_settings(8'd1, 8'd1, 8'd1);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd1023, 32'd1);
		offer_knob_beat(skcr_pkg::CMD_FILTER, 10'd0, 32'd2);

		// Random phases across several settings and idling modes
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin
					g = skcr_pkg::GAIN_RESET;
					db = skcr_pkg::DEADBAND_RESET;
					iv = skcr_pkg::INTERVAL_RESET;
				end
				1: begin g = 8'd255; db = 8'd0; iv = 8'd0; end
				2: begin g = 8'd0; db = 8'd255; iv = 8'd255; end
				3: begin g = 8'd1; db = 8'd1; iv = 8'd1; end
				4: begin g = 8'd128; db = 8'd8; iv = 8'd50; end
				7: begin g = 8'd200; db = 8'd3; iv = 8'd10; end
				default: begin
					g = 8'($urandom_range(255));
					db = 8'($urandom_range(12));
					iv = 8'($urandom_range(255));
				end
			endcase
			load_settings(g, db, iv);
			if (phase < 3) begin
				tx_idle_pct = 12;
				rx_idle_pct = 67;
			end else if (phase < 6) begin
				tx_idle_pct = 67;
				rx_idle_pct = 12;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			now_ms = (phase % 2 == 1) ? 32'hFFFF_FF00 : $urandom;
			walk_sample = $urandom_range(1023);

			// Long result hold-off while the sender keeps pushing
			if (phase == 1) begin
				tx_idle_pct = 0;
				rx_hold_cycles = 80;
				for (int k = 0; k < 20; k++)
					random_knob_beat();
				tx_idle_pct = 12;
			end

			for (int k = 0; k < PHASE_ITEMS; k++)
				random_knob_beat();
		end

		wait_for_results();
		repeat (5) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/skcr_pkg.sv
rtl/core/skcr_ema.sv
rtl/core/smoothed_knob_change_reporter.sv
verif/skcr_checker.sv
verif/testbench.sv
